FILE: rtl/core/persistent_range_sum_tree_defines.svh
// Assertion macros shared by the range-sum tree RTL.
// Depends on a clock named clk and a reset named rst in the including scope.
`ifndef PERSISTENT_RANGE_SUM_TREE_DEFINES_SVH
`define PERSISTENT_RANGE_SUM_TREE_DEFINES_SVH

// Same-cycle implication.
`define PRST_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("prst assertion failed");

// Next-cycle implication.
`define PRST_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("prst assertion failed");

`endif

FILE: rtl/core/prst_pkg.sv
// Package for the persistent range-sum tree: sizes, codes and the
// transfer, node, command and status types. No dependencies.
package prst_pkg;

  localparam int LEAVES       = 1024;
  localparam int LEVELS       = $clog2(LEAVES);
  localparam int PATH_NODES   = LEVELS + 1;
  localparam int LVL_W        = $clog2(PATH_NODES + 1);
  localparam int POOL_NODES   = 65536;
  localparam int NODE_W       = $clog2(POOL_NODES);
  localparam int FREE_W       = NODE_W + 1;
  localparam int MAX_VERSIONS = 1024;
  localparam int VER_W        = $clog2(MAX_VERSIONS);
  localparam int VCNT_W       = VER_W + 1;
  localparam int TOT_W        = 64;

  typedef enum logic [1:0] {
    REQ_SET  = 2'd0,
    REQ_SUM  = 2'd1,
    REQ_COPY = 2'd2,
    REQ_NONE = 2'd3
  } req_kind_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_POOL_FULL   = 2'd1,
    ST_BAD_VERSION = 2'd2,
    ST_TABLE_FULL  = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [9:0]         version;
    logic [9:0]         position;
    logic [10:0]        range_end;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic signed [63:0] range_total;
    logic [9:0]         new_version;
    logic [1:0]         status;
  } rsp_t;

  typedef struct packed {
    logic [TOT_W-1:0]  total;
    logic [NODE_W-1:0] left;
    logic [NODE_W-1:0] right;
  } node_t;

  typedef struct packed {
    logic             load_req;
    logic             desc_start;
    logic             start_pass;
    logic             desc_step;
    logic             pass_end;
    logic             wr_step;
    logic             wr_last;
    logic             do_copy;
    logic             set_res;
    status_t          res_code;
    logic             out_load;
    logic [LVL_W-1:0] lvl;
  } cmd_t;

  typedef struct packed {
    req_kind_t kind;
    logic      ver_ok;
    logic      pool_ok;
    logic      table_ok;
    logic      out_free;
  } sts_t;

endpackage

FILE: rtl/core/prst_ctrl.sv
// Controller for the range-sum tree: request sequencing and level counting.
// Depends on prst_pkg.
module prst_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  prst_pkg::sts_t sts,
  output prst_pkg::cmd_t cmd
);
  import prst_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_ROOT  = 6'b000010,
    S_DISP  = 6'b000100,
    S_DESC  = 6'b001000,
    S_WRITE = 6'b010000,
    S_FIN   = 6'b100000
  } state_t;

  localparam logic [LVL_W-1:0] LAST_LVL = LVL_W'(LEVELS);

  state_t           state, state_next;
  logic [LVL_W-1:0] lvl, lvl_next;
  logic             pass, pass_next;

  always_comb begin
    state_next = state;
    lvl_next   = lvl;
    pass_next  = pass;
    cmd        = '0;
    cmd.lvl    = lvl;
    req_stall  = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load_req = 1'b1;
          state_next   = S_ROOT;
        end
      end
      S_ROOT: state_next = S_DISP;
      S_DISP: begin
        lvl_next   = '0;
        pass_next  = 1'b0;
        state_next = S_FIN;
        priority if (sts.kind != REQ_NONE && !sts.ver_ok) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = ST_BAD_VERSION;
        end else if (sts.kind == REQ_SET) begin
          if (!sts.pool_ok) begin
            cmd.set_res  = 1'b1;
            cmd.res_code = ST_POOL_FULL;
          end else begin
            cmd.desc_start = 1'b1;
            state_next     = S_DESC;
          end
        end else if (sts.kind == REQ_SUM) begin
          cmd.desc_start = 1'b1;
          state_next     = S_DESC;
        end else if (sts.kind == REQ_COPY) begin
          if (!sts.table_ok) begin
            cmd.set_res  = 1'b1;
            cmd.res_code = ST_TABLE_FULL;
          end else begin
            cmd.do_copy = 1'b1;
          end
        end else begin
          cmd.set_res  = 1'b0;
        end
      end
      S_DESC: begin
        cmd.desc_step = 1'b1;
        if (lvl == LAST_LVL) begin
          lvl_next = '0;
          if (sts.kind == REQ_SET) begin
            state_next = S_WRITE;
          end else if (!pass) begin
            cmd.pass_end   = 1'b1;
            cmd.desc_start = 1'b1;
            cmd.start_pass = 1'b1;
            pass_next      = 1'b1;
          end else begin
            state_next = S_FIN;
          end
        end else begin
          lvl_next = lvl + 1'b1;
        end
      end
      S_WRITE: begin
        cmd.wr_step = 1'b1;
        if (lvl == LAST_LVL) begin
          cmd.wr_last = 1'b1;
          lvl_next    = '0;
          state_next  = S_FIN;
        end else begin
          lvl_next = lvl + 1'b1;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      lvl   <= '0;
      pass  <= 1'b0;
    end else begin
      state <= state_next;
      lvl   <= lvl_next;
      pass  <= pass_next;
    end
  end

endmodule

FILE: rtl/core/prst_dp.sv
// Datapath for the range-sum tree: node pool, version root table, path
// registers, prefix accumulator and result register. Depends on prst_pkg.
module prst_dp (
  input  logic           clk,
  input  logic           rst,
  input  prst_pkg::req_t req,
  input  prst_pkg::cmd_t cmd,
  output prst_pkg::sts_t sts,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output prst_pkg::rsp_t rsp
);
  import prst_pkg::*;

  localparam logic [LVL_W-1:0] LAST_LVL = LVL_W'(LEVELS);

  req_t              rq;
  logic [VCNT_W-1:0] vcount;
  logic [FREE_W-1:0] nfree;
  logic              root1_set;

  logic [NODE_W-1:0] root_mem [MAX_VERSIONS];
  logic [NODE_W-1:0] root_q;
  logic              root_zero;
  logic [NODE_W-1:0] root_val;

  node_t             node_mem [POOL_NODES];
  node_t             node_q;
  logic              node_zero;
  node_t             node_val;
  logic [NODE_W-1:0] node_raddr;
  node_t             node_wdata;
  logic [NODE_W-1:0] node_waddr;
  logic [NODE_W-1:0] link;

  logic [LEVELS-1:0] xs;
  logic              xtop;
  logic              prevright;
  logic [TOT_W-1:0]  acc, acc_next, addend, pfx, delta;
  logic [NODE_W-1:0] other [PATH_NODES];
  logic [TOT_W-1:0]  oldtot [PATH_NODES];
  logic              dir, gr, pr;
  logic [10:0]       bclip, target;
  logic [TOT_W-1:0]  value_ext;
  status_t           res_status;
  logic [VER_W-1:0]  res_newv;
  logic              sum_en;

  assign root_val  = root_zero ? '0 : root_q;
  assign node_val  = node_zero ? '0 : node_q;
  assign value_ext = {{(TOT_W-32){rq.value[31]}}, rq.value};
  assign bclip     = (rq.range_end > 11'(LEAVES)) ? 11'(LEAVES) : rq.range_end;
  assign target    = (cmd.start_pass || sts.kind == REQ_SET) ? {1'b0, rq.position} : bclip;

  assign dir    = xs[LEVELS-1] & (cmd.lvl != LAST_LVL);
  assign pr     = prevright & ~xtop;
  assign gr     = xtop ? (cmd.lvl == '0) : dir;
  assign addend = (gr == pr) ? '0 : (gr ? node_val.total : -node_val.total);
  assign acc_next = acc + addend;

  assign node_raddr = cmd.desc_start ? root_val : (dir ? node_val.right : node_val.left);

  assign node_waddr = nfree[NODE_W-1:0] + NODE_W'(cmd.lvl);
  assign link       = node_waddr + 1'b1;

  always_comb begin
    node_wdata.total = oldtot[cmd.lvl] + delta;
    if (cmd.lvl == LAST_LVL) begin
      node_wdata.left  = '0;
      node_wdata.right = '0;
    end else if (xs[LEVELS-1]) begin
      node_wdata.left  = other[cmd.lvl];
      node_wdata.right = link;
    end else begin
      node_wdata.left  = link;
      node_wdata.right = other[cmd.lvl];
    end
  end

  assign sts.kind     = req_kind_t'(rq.req_type);
  assign sts.ver_ok   = (rq.version != '0) && ({1'b0, rq.version} < vcount);
  assign sts.pool_ok  = ((FREE_W+1)'(nfree) + (FREE_W+1)'(PATH_NODES))
                        <= (FREE_W+1)'(POOL_NODES);
  assign sts.table_ok = vcount < VCNT_W'(MAX_VERSIONS);
  assign sts.out_free = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    node_q    <= node_mem[node_raddr];
    node_zero <= (node_raddr == '0);
    if (cmd.wr_step) begin
      node_mem[node_waddr] <= node_wdata;
    end
  end

  always_ff @(posedge clk) begin
    root_q    <= root_mem[rq.version];
    root_zero <= (rq.version == '0) || (rq.version == VER_W'(1) && !root1_set);
    if (cmd.wr_last) begin
      root_mem[rq.version] <= nfree[NODE_W-1:0];
    end else if (cmd.do_copy) begin
      root_mem[vcount[VER_W-1:0]] <= root_val;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      rq <= req;
    end
    if (cmd.desc_step) begin
      other[cmd.lvl]  <= dir ? node_val.left : node_val.right;
      oldtot[cmd.lvl] <= node_val.total;
      if (cmd.lvl == LAST_LVL) begin
        delta <= value_ext - node_val.total;
      end
    end
    if (cmd.pass_end) begin
      pfx <= acc_next;
    end
    if (cmd.desc_start) begin
      acc       <= '0;
      prevright <= 1'b0;
      xs        <= target[LEVELS-1:0];
      xtop      <= target[LEVELS];
    end else if (cmd.desc_step) begin
      acc       <= acc_next;
      prevright <= gr;
      if (cmd.lvl == LAST_LVL) begin
        xs <= rq.position;
      end else begin
        xs <= xs << 1;
      end
    end else if (cmd.wr_step) begin
      xs <= xs << 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vcount     <= VCNT_W'(2);
      nfree      <= FREE_W'(2);
      root1_set  <= 1'b0;
      rsp_valid  <= 1'b0;
      res_status <= ST_OK;
      res_newv   <= '0;
      sum_en     <= 1'b0;
    end else begin
      if (cmd.load_req) begin
        res_status <= ST_OK;
        res_newv   <= '0;
        sum_en     <= 1'b0;
      end
      if (cmd.set_res) begin
        res_status <= cmd.res_code;
      end
      if (cmd.desc_start && sts.kind == REQ_SUM && !cmd.start_pass) begin
        sum_en <= ({1'b0, rq.position} < bclip);
      end
      if (cmd.wr_last) begin
        nfree <= nfree + FREE_W'(PATH_NODES);
        if (rq.version == VER_W'(1)) begin
          root1_set <= 1'b1;
        end
      end
      if (cmd.do_copy) begin
        res_newv <= vcount[VER_W-1:0];
        vcount   <= vcount + 1'b1;
      end
      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsp.range_total <= sum_en ? (pfx - acc) : '0;
      rsp.new_version <= res_newv;
      rsp.status      <= res_status;
    end
  end

endmodule

FILE: rtl/core/persistent_range_sum_tree.sv
// Persistent range-sum tree top level; depends on prst_pkg, prst_ctrl, prst_dp.
// One request at a time: a set reads and then rewrites the 11 pool nodes on its path, and a
// sum makes two prefix walks of 11 node reads each; a copy or a rejected request skips the
// walks. The controller returns to idle as the result enters the output register and only
// then takes the next request; a stalled result delays it.
// Reset is synchronous; versions 0 and 1 and node 0 read as empty afterward.
`include "persistent_range_sum_tree_defines.svh"
module persistent_range_sum_tree (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  prst_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output prst_pkg::rsp_t rsp
);
  import prst_pkg::*;

  cmd_t cmd;
  sts_t sts;

  prst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  prst_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  `PRST_ASSERT_NEXT(a_busy_after_transfer, req_valid && !req_stall, req_stall)
  `PRST_ASSERT_IMPL(a_load_when_free, cmd.out_load, !rsp_valid || !rsp_stall)
  `PRST_ASSERT_NEXT(a_result_follows_load, cmd.out_load, rsp_valid)

endmodule
